// ===== hw/rtl/round_robin_task_scheduler_macros.svh =====
// assertion macros for the round robin task scheduler
`ifndef ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH
`ifndef ASSERT_OFF
`define RRTS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RRTS_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RRTS_ASSERT(label, clk, rst, prop, msg)
`define RRTS_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/rrts_pkg.sv =====
// shared types and constants of the round robin task scheduler
`timescale 1ns / 1ps
package rrts_pkg;
  localparam int NumProcs = 8;
  localparam int PidW = $clog2(NumProcs);
  localparam int MaskW = 8;

  typedef enum logic [1:0] {
    REQ_SCHED = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  localparam logic [2:0] ST_RUNNING    = 3'd0;
  localparam logic [2:0] ST_READY      = 3'd1;
  localparam logic [2:0] ST_SLEEPING   = 3'd2;
  localparam logic [2:0] ST_PAUSED     = 3'd3;
  localparam logic [2:0] ST_TERMINATED = 3'd4;
  localparam logic [3:0] SIG_ALARM     = 4'd14;

  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] proc_id;
    logic [2:0] new_state;
    logic [31:0] wake_tick;
    logic [31:0] alarm_at;
    logic [31:0] tick_value;
  } in_t;

  typedef struct packed {
    logic [2:0] run_pid;
    logic [31:0] now_tick;
    logic [7:0] alarm_mask;
    logic halted;
    logic stuck;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input beat and apply writes
    logic demote;    // demote running, clear scan
    logic scan;      // examine entry at idx
    logic advance;   // step entry idx over the event tick
    logic pick;      // choose the found ready process
    logic [PidW-1:0] idx;
    logic second;    // second ready search
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_sched;
    logic alive;
    logic found;
    logic has_event;
  } sts_t;
endpackage

// ===== hw/rtl/rrts_if.sv =====
// valid/ready channel carrying one payload beat
`timescale 1ns / 1ps
interface rrts_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/rrts_ctrl.sv =====
// scheduler sequencer: walks the table entries one per cycle
`timescale 1ns / 1ps
module rrts_ctrl import rrts_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DEMOT = 7'b0000010,
    S_SCAN1 = 7'b0000100,
    S_ADV   = 7'b0001000,
    S_SCAN2 = 7'b0010000,
    S_PICK  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic [PidW-1:0] idx, idx_next;
  localparam logic [PidW-1:0] LastIdx = PidW'(NumProcs - 1);

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    idx_next = idx;
    cmd = '0;
    cmd.idx = idx;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DEMOT;
        end
      end
      S_DEMOT: begin
        if (!sts.is_sched) begin
          state_next = S_OUT;
        end else begin
          cmd.demote = 1'b1;
          idx_next = '0;
          state_next = S_SCAN1;
        end
      end
      S_SCAN1: begin
        cmd.scan = 1'b1;
        idx_next = idx + 1'b1;
        if (idx == LastIdx) begin
          idx_next = '0;
          state_next = S_ADV;
        end
      end
      S_ADV: begin
        // halted, ready found, or stuck skip the time jump
        if (!sts.alive || sts.found || !sts.has_event) begin
          state_next = S_PICK;
        end else begin
          cmd.advance = 1'b1;
          idx_next = idx + 1'b1;
          if (idx == LastIdx) begin
            idx_next = '0;
            state_next = S_SCAN2;
          end
        end
      end
      S_SCAN2: begin
        cmd.scan = 1'b1;
        cmd.second = 1'b1;
        idx_next = idx + 1'b1;
        if (idx == LastIdx) begin
          idx_next = '0;
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        cmd.pick = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx <= '0;
    end else begin
      state <= state_next;
      idx <= idx_next;
    end
  end
endmodule

// ===== hw/rtl/rrts_dp.sv =====
// scheduler datapath: task table, tick count and search registers
`timescale 1ns / 1ps
module rrts_dp import rrts_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  in_t  in_data,
  input  cmd_t cmd,
  output sts_t sts,
  output out_t out_data
);
  logic [2:0]  proc_states [NumProcs];
  logic [31:0] wake_ticks [NumProcs];
  logic [31:0] alarm_ticks [NumProcs];
  logic [NumProcs-1:0] signal_pending;
  logic [PidW-1:0] running_pid;
  logic [31:0] tick_count;

  in_t req;
  logic alive, found, has_event, halted, stuck;
  logic [PidW-1:0] best_pid;
  logic [PidW:0] best_gap;
  logic [32:0] best_steps;
  logic [MaskW-1:0] mask;

  function automatic logic [32:0] steps_until(input logic [31:0] tgt, input logic [31:0] now);
    logic [31:0] first;
    first = now + 32'd1;
    if (tgt <= first) return 33'd1;
    return {1'b0, tgt - first} + 33'd1;
  endfunction

  // entry under scan, with the demotion folded in
  logic [2:0] st_i;
  logic [32:0] ws, as;
  logic [PidW:0] gap;
  logic [PidW-1:0] rel;
  logic ev_w, ev_a;
  always_comb begin
    st_i = proc_states[cmd.idx];
    ws = steps_until(wake_ticks[cmd.idx], tick_count);
    as = steps_until(alarm_ticks[cmd.idx], tick_count);
    rel = cmd.idx - running_pid;
    // circular distance after the running one, running itself last
    gap = (rel == '0) ? (PidW+1)'(NumProcs) : {1'b0, rel};
    ev_w = (st_i == ST_SLEEPING);
    ev_a = (st_i == ST_PAUSED) && (alarm_ticks[cmd.idx] != 32'd0);
  end

  assign sts.is_sched = (req.req_type == REQ_SCHED);
  assign sts.alive = alive;
  assign sts.found = found;
  assign sts.has_event = has_event;

  assign out_data.run_pid = 3'(running_pid);
  assign out_data.now_tick = tick_count;
  assign out_data.alarm_mask = mask;
  assign out_data.halted = halted;
  assign out_data.stuck = stuck;

  always_ff @(posedge clk) begin
    if (cmd.load) req <= in_data;
    if (rst) begin
      for (int i = 0; i < NumProcs; i++) begin
        proc_states[i] <= ST_TERMINATED;
        wake_ticks[i] <= '0;
        alarm_ticks[i] <= '0;
      end
      signal_pending <= '0;
      running_pid <= '0;
      tick_count <= '0;
      mask <= '0;
      halted <= 1'b0;
      stuck <= 1'b0;
      alive <= 1'b0;
      found <= 1'b0;
      has_event <= 1'b0;
      best_pid <= '0;
      best_gap <= '0;
      best_steps <= '0;
    end else begin
      if (cmd.load) begin
        mask <= '0;
        halted <= 1'b0;
        stuck <= 1'b0;
        if (in_data.req_type == REQ_WRITE && 32'(in_data.proc_id) < NumProcs) begin
          proc_states[PidW'(in_data.proc_id)] <= in_data.new_state;
          wake_ticks[PidW'(in_data.proc_id)] <= in_data.wake_tick;
          alarm_ticks[PidW'(in_data.proc_id)] <= in_data.alarm_at;
        end else if (in_data.req_type == REQ_TICK) begin
          tick_count <= in_data.tick_value;
        end
      end
      if (cmd.demote) begin
        if (proc_states[running_pid] == ST_RUNNING) proc_states[running_pid] <= ST_READY;
        alive <= 1'b0;
        found <= 1'b0;
        has_event <= 1'b0;
        best_gap <= '1;
        best_steps <= '1;
      end
      if (cmd.scan) begin
        if (st_i != ST_TERMINATED) alive <= 1'b1;
        if (st_i == ST_READY && (!found || gap < best_gap)) begin
          found <= 1'b1;
          best_pid <= cmd.idx;
          best_gap <= gap;
        end
        if (!cmd.second) begin
          if (ev_w || ev_a) has_event <= 1'b1;
          if (ev_w && ev_a)
            best_steps <= (ws < as ? ws : as) < best_steps ? (ws < as ? ws : as) : best_steps;
          else if (ev_w && ws < best_steps) best_steps <= ws;
          else if (ev_a && as < best_steps) best_steps <= as;
        end
      end
      if (cmd.advance) begin
        if (st_i == ST_SLEEPING && ws <= best_steps) proc_states[cmd.idx] <= ST_READY;
        if (alarm_ticks[cmd.idx] != 32'd0 && as <= best_steps) begin
          signal_pending[cmd.idx] <= 1'b1;
          alarm_ticks[cmd.idx] <= '0;
          if (32'(cmd.idx) < MaskW) mask[3'(cmd.idx)] <= 1'b1;
          if (st_i == ST_PAUSED) proc_states[cmd.idx] <= ST_READY;
        end
        // tick moves once the last entry has been tested
        if (cmd.idx == PidW'(NumProcs - 1)) tick_count <= tick_count + best_steps[31:0];
      end
      if (cmd.pick) begin
        if (!alive) halted <= 1'b1;
        else if (!found) stuck <= 1'b1;
        else begin
          running_pid <= best_pid;
          proc_states[best_pid] <= ST_RUNNING;
        end
      end
    end
  end
endmodule

// ===== hw/rtl/round_robin_task_scheduler.sv =====
// Round robin task scheduler: one result beat per request beat. A schedule
// request walks the 8-entry task table one entry a cycle in up to three
// passes, the later ones only when no task is ready and time jumps to the
// earliest wake or alarm. A new request is taken once the result is
// delivered.
`timescale 1ns / 1ps
`include "round_robin_task_scheduler_macros.svh"
module round_robin_task_scheduler import rrts_pkg::*; (
  input logic clk,
  input logic rst,
  rrts_if.sink   req,
  rrts_if.source rsp
);
  cmd_t cmd;
  sts_t sts;
  out_t out_data;

  rrts_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .sts, .cmd
  );

  rrts_dp u_dp (
    .clk, .rst,
    .in_data(req.data), .cmd, .sts, .out_data
  );

  assign rsp.data = out_data;

  `RRTS_ASSERT(a_no_overlap, clk, rst, !(req.ready && rsp.valid), "input taken while result pending")
  `RRTS_ASSERT(a_flags_excl, clk, rst, rsp.valid |-> !(out_data.halted && out_data.stuck), "halted and stuck together")
  `RRTS_ASSERT(a_mask_stuck, clk, rst, (rsp.valid && (out_data.stuck || out_data.halted)) |-> out_data.alarm_mask == '0, "alarm fired without time jump")
  `RRTS_ASSERT_RST(a_reset_idle, clk, $past(rst) |-> !rsp.valid, "result right after reset")
endmodule

// ===== sim/tb.sv =====
// testbench for the round robin task scheduler: predicted results checked beat by beat
`timescale 1ns / 1ps
module tb;
  import rrts_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rrts_if #(.T(in_t))  req_ch (.clk(clk));
  rrts_if #(.T(out_t)) rsp_ch (.clk(clk));

  round_robin_task_scheduler dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch.sink),
    .rsp(rsp_ch.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // scheduler state as predicted
  logic [2:0]  task_state [NumProcs] = '{default: ST_TERMINATED};
  logic [31:0] task_wake [NumProcs] = '{default: '0};
  logic [31:0] task_alarm [NumProcs] = '{default: '0};
  logic        sig_pend [NumProcs] = '{default: 1'b0};
  logic [2:0]  cur_pid = '0;
  logic [31:0] sys_tick = '0;

  in_t  pending_reqs [$];
  out_t sched_results [$];
  int   mismatches = 0;
  int   cycles = 0;
  bit   all_sent = 1'b0;
  bit   calm = 1'b0;

  function automatic longint unsigned ticks_to(logic [31:0] target);
    logic [31:0] first;
    first = sys_tick + 32'd1;
    if (target <= first) return 1;
    return longint'(target - first) + 1;
  endfunction

  function automatic int next_ready();
    int p;
    for (int k = 1; k <= NumProcs; k++) begin
      p = (cur_pid + k) % NumProcs;
      if (task_state[p] == ST_READY) return p;
    end
    return -1;
  endfunction

  function automatic out_t schedule_step(in_t r);
    out_t o;
    bit alive;
    int nxt;
    longint unsigned best, s;
    o = '0;
    case (req_t'(r.req_type))
      REQ_WRITE: begin
        task_state[r.proc_id] = r.new_state;
        task_wake[r.proc_id]  = r.wake_tick;
        task_alarm[r.proc_id] = r.alarm_at;
      end
      REQ_TICK: sys_tick = r.tick_value;
      REQ_SCHED: begin
        if (task_state[cur_pid] == ST_RUNNING) task_state[cur_pid] = ST_READY;
        alive = 1'b0;
        for (int i = 0; i < NumProcs; i++)
          if (task_state[i] != ST_TERMINATED) alive = 1'b1;
        if (!alive) begin
          o.halted = 1'b1;
        end else begin
          nxt = next_ready();
          if (nxt < 0) begin
            best = '1;
            for (int i = 0; i < NumProcs; i++) begin
              if (task_state[i] == ST_SLEEPING) begin
                s = ticks_to(task_wake[i]);
                if (s < best) best = s;
              end
              if (task_state[i] == ST_PAUSED && task_alarm[i] != 0) begin
                s = ticks_to(task_alarm[i]);
                if (s < best) best = s;
              end
            end
            if (best == '1) begin
              o.stuck = 1'b1;
            end else begin
              for (int i = 0; i < NumProcs; i++) begin
                if (task_state[i] == ST_SLEEPING && ticks_to(task_wake[i]) <= best)
                  task_state[i] = ST_READY;
                if (task_alarm[i] != 0 && ticks_to(task_alarm[i]) <= best) begin
                  sig_pend[i] = 1'b1;
                  task_alarm[i] = '0;
                  o.alarm_mask[i] = 1'b1;
                  if (task_state[i] == ST_PAUSED) task_state[i] = ST_READY;
                end
              end
              sys_tick = sys_tick + best[31:0];
              nxt = next_ready();
            end
          end
          if (nxt >= 0) begin
            cur_pid = nxt[2:0];
            task_state[cur_pid] = ST_RUNNING;
          end
        end
      end
      default: ;
    endcase
    o.run_pid = cur_pid;
    o.now_tick = sys_tick;
    return o;
  endfunction

  function automatic in_t mk(req_t t, int pid, int st, logic [31:0] w, logic [31:0] a,
                             logic [31:0] tv);
    in_t r;
    r.req_type = t; r.proc_id = 3'(pid); r.new_state = 3'(st);
    r.wake_tick = w; r.alarm_at = a; r.tick_value = tv;
    return r;
  endfunction

  function automatic in_t rand_req(int mode);
    in_t r;
    int pick;
    r = 104'({$urandom, $urandom, $urandom, $urandom});
    pick = $urandom_range(0, 99);
    if (mode == 1) begin
      r.req_type = (pick < 45) ? REQ_SCHED : (pick < 85) ? REQ_WRITE
                 : (pick < 95) ? REQ_TICK : REQ_NONE;
      if ($urandom_range(0, 9) < 8) r.new_state = 3'($urandom_range(0, 4));
      // keep events near the current tick so the jumps stay meaningful
      if ($urandom_range(0, 3) != 0) r.wake_tick = sys_tick + $urandom_range(0, 40) - 5;
      case ($urandom_range(0, 3))
        0: r.alarm_at = '0;
        1, 2: r.alarm_at = sys_tick + $urandom_range(0, 40) - 5;
        default: ;
      endcase
      if ($urandom_range(0, 3) != 0) r.tick_value = $urandom_range(0, 200);
    end else begin
      r.req_type = 2'($urandom_range(0, 3));
    end
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (pending_reqs.size() > 0 && (calm || $urandom_range(0, 99) >= 14)) begin
        req_ch.data  <= pending_reqs.pop_front();
        req_ch.valid <= 1'b1;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // predict on acceptance, check results
  always @(posedge clk) begin
    out_t exp_o;
    cycles <= cycles + 1;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 14);
      if (req_ch.valid && req_ch.ready) sched_results.push_back(schedule_step(req_ch.data));
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (sched_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %p", rsp_ch.data);
        end else begin
          exp_o = sched_results.pop_front();
          if (rsp_ch.data !== exp_o) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp_o, rsp_ch.data);
          end
        end
      end
    end
  end

  initial begin
    // directed: halt, stuck, sleeper wake, alarm wake, tick wrap, odd states, round robin
    pending_reqs.push_back(mk(REQ_SCHED, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_NONE, 7, 7, '1, '1, '1));
    pending_reqs.push_back(mk(REQ_WRITE, 3, 5, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_SCHED, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_WRITE, 3, 2, 32'd20, 0, 0));
    pending_reqs.push_back(mk(REQ_WRITE, 7, 3, 0, 32'd10, 0));
    pending_reqs.push_back(mk(REQ_SCHED, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_SCHED, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_TICK, 0, 0, 0, 0, 32'hFFFF_FFFE));
    pending_reqs.push_back(mk(REQ_WRITE, 0, 2, 32'd1, 32'hFFFF_FFFF, 0));
    pending_reqs.push_back(mk(REQ_WRITE, 3, 4, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_WRITE, 7, 6, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_SCHED, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_WRITE, 1, 1, '1, 0, 0));
    pending_reqs.push_back(mk(REQ_WRITE, 5, 1, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_SCHED, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_SCHED, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_SCHED, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_TICK, 0, 0, 0, 0, '1));
    for (int i = 0; i < NumProcs; i++) pending_reqs.push_back(mk(REQ_WRITE, i, 4, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_SCHED, 0, 0, 0, 0, 0));
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // random stretch; predictor state tracks only for bias, so wait for drain before each request
    for (int n = 0; n < 1200; n++) begin
      if (n == 300) calm = 1'b1;
      if (n == 500) calm = 1'b0;
      while (pending_reqs.size() > 0 || sched_results.size() > 0) @(posedge clk);
      pending_reqs.push_back(rand_req($urandom_range(0, 9) < 8));
    end
    all_sent = 1'b1;
  end

  initial begin
    wait (all_sent);
    while (pending_reqs.size() > 0 || sched_results.size() > 0 || req_ch.valid)
      @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    wait (cycles >= 400000);
    $display("Verification failed");
    $finish;
  end
endmodule
